FILE: rtl/core/bitmap_first_fit_allocator_macros.svh
// assertion macros for the bitmap allocator checker
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_MACROS_SVH
// implication checked on every clock, quiet during reset
`define BFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define BFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: rtl/core/bffa_pkg.sv
// shared types, constants and codes of the bitmap allocator
package bffa_pkg;
    localparam int NUM_CHUNKS = 1024;
    localparam int MAX_RUN    = 56;
    localparam int IDX_W      = $clog2(NUM_CHUNKS);
    localparam int WORD_W     = 64;
    localparam int NUM_WORDS  = NUM_CHUNKS / WORD_W;
    localparam int WADDR_W    = $clog2(NUM_WORDS);
    localparam int BIT_W      = $clog2(WORD_W);
    localparam int CNT_W      = 6;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_LARGE    = 3'd2;
    localparam logic [2:0] ST_NOSPACE  = 3'd3;
    localparam logic [2:0] ST_NOTALLOC = 3'd4;

    typedef struct packed {
        logic        action;
        logic [11:0] request_bytes;
        logic [9:0]  release_index;
    } in_beat_t;

    typedef struct packed {
        logic [2:0] status;
        logic [9:0] chunk_index;
        logic [5:0] chunk_count;
    } out_beat_t;

    // controller to datapath
    typedef struct packed {
        logic load;      // capture request, start scan at chunk 0
        logic step;      // test current chunk and advance
        logic claim;     // set current chunk in map (mark used)
        logic release_c; // clear current chunk in map
        logic fin_alloc; // write run length at start
        logic fin_free;  // clear run length at start
        logic rl_read;   // read run length at release index
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic found;     // run of needed length complete at cursor
        logic at_end;    // cursor reached map end
        logic rl_zero;   // recorded length is zero
        logic run_done;  // claim or release pass finished
        logic ready;     // map word under the cursor is loaded
        logic busy;      // clearing pass after reset still running
    } dp_stat_t;
endpackage

FILE: rtl/core/bffa_datapath.sv
// bitmap, run length memory and scan cursor
module bffa_datapath
    import bffa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_beat_t  req,
    input  dp_cmd_t   cmd,
    output dp_stat_t  stat,
    output logic [IDX_W-1:0] start_idx,
    output logic [CNT_W-1:0] need_cnt
);
    // map words hold used bits (1 = allocated), zeroed by the clearing pass
    logic [WORD_W-1:0]  map_mem [NUM_WORDS];
    logic [CNT_W-1:0]   rl_mem [NUM_CHUNKS];
    logic [WORD_W-1:0]  map_rd_reg;
    logic [WADDR_W-1:0] map_rd_addr_reg;
    logic [CNT_W-1:0]   rl_rd_reg;

    logic [WORD_W-1:0]  wbuf_reg;    // working copy of one map word
    logic [WADDR_W-1:0] waddr_reg;
    logic               wok_reg;
    logic [IDX_W:0]     clr_reg;     // clearing pass position

    logic [IDX_W:0]   cur_reg;     // chunk under test
    logic [IDX_W-1:0] start_reg;
    logic [CNT_W-1:0] need_reg;
    logic [CNT_W-1:0] len_reg;     // free run seen / chunks handled
    logic [12:0]      tag_sum;
    logic [12:0]      total;
    logic             too_large;

    logic [WADDR_W-1:0] cur_word;
    logic [BIT_W-1:0]   cur_bit;
    logic               clearing;
    logic               word_ok;
    logic               cur_used;
    logic               map_wr;
    logic [WORD_W-1:0]  wbuf_next;

    assign tag_sum   = {1'b0, req.request_bytes} + 13'd8;
    assign total     = tag_sum + 13'd3;
    assign too_large = (tag_sum[12:2] > 11'(MAX_RUN));

    assign cur_word = cur_reg[IDX_W-1:BIT_W];
    assign cur_bit  = cur_reg[BIT_W-1:0];
    assign clearing = !clr_reg[IDX_W];
    assign word_ok  = wok_reg && (waddr_reg == cur_word) && !cur_reg[IDX_W];
    assign cur_used = wbuf_reg[cur_bit];
    assign map_wr   = cmd.claim || cmd.release_c;

    always_comb
    begin
        wbuf_next = wbuf_reg;
        wbuf_next[cur_bit] = cmd.claim;
    end

    // map words: one write port, registered read at the cursor's word
    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            if (clr_reg[IDX_W-1:WADDR_W] == '0)
            begin
                map_mem[clr_reg[WADDR_W-1:0]] <= '0;
            end
        end
        else if (map_wr)
        begin
            map_mem[waddr_reg] <= wbuf_next;
        end
        map_rd_reg <= map_mem[cur_word];
    end

    always_ff @(posedge clk)
    begin
        if (clearing)
        begin
            rl_mem[clr_reg[IDX_W-1:0]] <= '0;
        end
        else if (cmd.fin_alloc)
        begin
            rl_mem[start_reg] <= need_reg;
        end
        else if (cmd.fin_free)
        begin
            rl_mem[start_reg] <= '0;
        end
        rl_rd_reg <= rl_mem[req.release_index];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg         <= '0;
            map_rd_addr_reg <= '0;
            wbuf_reg        <= '0;
            waddr_reg       <= '0;
            wok_reg         <= 1'b0;
            cur_reg         <= '0;
            start_reg       <= '0;
            need_reg        <= '0;
            len_reg         <= '0;
        end
        else
        begin
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            map_rd_addr_reg <= cur_word;
            // take the fetched word once it belongs to the cursor
            if (!clearing && !word_ok && !cur_reg[IDX_W] && map_rd_addr_reg == cur_word)
            begin
                wbuf_reg  <= map_rd_reg;
                waddr_reg <= cur_word;
                wok_reg   <= 1'b1;
            end
            if (cmd.load)
            begin
                cur_reg   <= '0;
                start_reg <= req.action ? req.release_index : '0;
                len_reg   <= '0;
                need_reg  <= too_large ? '0 : total[7:2];
            end
            if (cmd.rl_read)
            begin
                need_reg <= rl_rd_reg;
                cur_reg  <= {1'b0, start_reg};
            end
            if (cmd.step)
            begin
                if (cur_used)
                begin
                    len_reg   <= '0;
                    start_reg <= IDX_W'(cur_reg + 1'b1);
                end
                else
                begin
                    len_reg <= len_reg + 1'b1;
                end
                cur_reg <= cur_reg + 1'b1;
            end
            if (map_wr)
            begin
                wbuf_reg <= wbuf_next;
                cur_reg  <= cur_reg + 1'b1;
                len_reg  <= len_reg + 1'b1;
            end
            if (cmd.fin_alloc)
            begin
                cur_reg <= {1'b0, start_reg};
                len_reg <= '0;
            end
        end
    end

    assign stat.found    = (len_reg == need_reg);
    assign stat.at_end   = cur_reg[IDX_W];
    assign stat.rl_zero  = (need_reg == '0);
    assign stat.run_done = (len_reg == need_reg) || cur_reg[IDX_W];
    assign stat.ready    = word_ok;
    assign stat.busy     = clearing;
    assign start_idx = start_reg;
    assign need_cnt  = need_reg;
endmodule

FILE: rtl/core/bffa_ctrl.sv
// sequencer for allocate and free requests
module bffa_ctrl
    import bffa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  in_beat_t  req,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t rsp,
    output dp_cmd_t   cmd,
    input  dp_stat_t  stat,
    input  logic [IDX_W-1:0] start_idx,
    input  logic [CNT_W-1:0] need_cnt
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CLAIM = 3'd2;
    localparam logic [2:0] S_RDRL  = 3'd3;
    localparam logic [2:0] S_REL   = 3'd4;
    localparam logic [2:0] S_CHKA  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    out_beat_t  rsp_reg, rsp_next;
    logic       zero_reg, zero_next;

    assign in_stall  = (state_reg != S_IDLE) || ov_reg || stat.busy;
    assign out_valid = ov_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && out_stall;
        rsp_next   = rsp_reg;
        zero_next  = zero_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    cmd.load  = 1'b1;
                    zero_next = (req.request_bytes == '0);
                    state_next = req.action ? S_RDRL : S_CHKA;
                end
            end
            S_CHKA:
            begin
                if (zero_reg || stat.rl_zero)
                begin
                    rsp_next = '{zero_reg ? ST_ZERO : ST_LARGE, '0, '0};
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.found)
                begin
                    cmd.fin_alloc = 1'b1;
                    state_next = S_CLAIM;
                end
                else if (stat.at_end)
                begin
                    rsp_next = '{ST_NOSPACE, '0, '0};
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.ready)
                begin
                    cmd.step = 1'b1;
                end
            end
            S_CLAIM:
            begin
                if (stat.run_done)
                begin
                    rsp_next = '{ST_OK, start_idx, need_cnt};
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.ready)
                begin
                    cmd.claim = 1'b1;
                end
            end
            S_RDRL:
            begin
                cmd.rl_read = 1'b1;
                state_next = S_REL;
                zero_next = 1'b1;
            end
            S_REL:
            begin
                if (zero_reg)
                begin
                    zero_next = 1'b0;
                    if (stat.rl_zero)
                    begin
                        rsp_next = '{ST_NOTALLOC, '0, '0};
                        ov_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.run_done)
                begin
                    cmd.fin_free = 1'b1;
                    rsp_next = '{ST_OK, start_idx, need_cnt};
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (stat.ready)
                begin
                    cmd.release_c = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
            zero_reg  <= zero_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end
endmodule

FILE: rtl/core/bitmap_first_fit_allocator.sv
// top level of the bitmap first-fit chunk allocator
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------------------------------
//  request | in_valid  | in_stall  | in_data  (action, bytes, index)
//  result  | out_valid | out_stall | out_data (status, index, count)
//
// allocate: size check, then a scan of one chunk per cycle while the cursor's map word is
// loaded (it stalls to fetch each new word), no space at the map end, else a claim pass
// free: the run length at the index is read, an empty index refused, else a release pass
// one request in flight; a new beat is taken only once the result is taken
// after reset a clearing pass zeroes map and run lengths, input stalled
// a stalled result holds and blocks the next request
module bitmap_first_fit_allocator
    import bffa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_beat_t out_data
);
    dp_cmd_t          cmd;
    dp_stat_t         stat;
    logic [IDX_W-1:0] start_idx;
    logic [CNT_W-1:0] need_cnt;

    // controller sequences scan, claim and release passes
    bffa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req       (in_data),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .rsp       (out_data),
        .cmd       (cmd),
        .stat      (stat),
        .start_idx (start_idx),
        .need_cnt  (need_cnt)
    );

    // datapath keeps the map, run lengths and cursor
    bffa_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .start_idx (start_idx),
        .need_cnt  (need_cnt)
    );
endmodule

FILE: rtl/core/bffa_checker.sv
// port-level checks for the allocator, bound to the top level
`include "bitmap_first_fit_allocator_macros.svh"
module bffa_checker
    import bffa_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_stall,
    input in_beat_t  in_data,
    input logic      out_valid,
    input logic      out_stall,
    input out_beat_t out_data
);
    `BFA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "result dropped while stalled")
    `BFA_ASSERT_IMP(a_busy, clk, rst_n, out_valid, in_stall, "request taken with result pending")
    `BFA_ASSERT_IMP(a_err0, clk, rst_n, out_valid && out_data.status != ST_OK, out_data.chunk_count == '0 && out_data.chunk_index == '0, "error result carries data")
    `BFA_ASSERT_IMP(a_okcnt, clk, rst_n, out_valid && out_data.status == ST_OK, out_data.chunk_count != '0, "ok result with zero count")
endmodule

bind bitmap_first_fit_allocator bffa_checker u_chk (.*);

FILE: verif/bitmap_first_fit_allocator_chk.sv
// checker for the bitmap allocator: watches both channels, predicts and compares results
module bitmap_first_fit_allocator_chk
    import bffa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_stall,
    input  in_beat_t  in_data,
    input  logic      out_valid,
    input  logic      out_stall,
    input  out_beat_t out_data,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic             chunk_free [NUM_CHUNKS];
    logic [CNT_W-1:0] run_len [NUM_CHUNKS];
    out_beat_t        expected_q [$];

    assign pending = expected_q.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic out_beat_t allocate_chunks(input logic [11:0] bytes);
        out_beat_t r;
        int total;
        int need;
        bit ok;
        r = '0;
        if (bytes == 0)
        begin
            r.status = ST_ZERO;
            return r;
        end
        total = bytes + 8;
        if ((total >> 2) > MAX_RUN)
        begin
            r.status = ST_LARGE;
            return r;
        end
        need = (total + 3) >> 2;
        for (int s = 0; s + need <= NUM_CHUNKS; s++)
        begin
            ok = 1;
            for (int k = 0; k < need && ok; k++)
                if (!chunk_free[s + k])
                    ok = 0;
            if (ok)
            begin
                for (int k = 0; k < need; k++)
                    chunk_free[s + k] = 0;
                run_len[s] = need[CNT_W-1:0];
                r.status = ST_OK;
                r.chunk_index = s[9:0];
                r.chunk_count = need[5:0];
                return r;
            end
        end
        r.status = ST_NOSPACE;
        return r;
    endfunction

    function automatic out_beat_t release_chunks(input logic [9:0] idx);
        out_beat_t r;
        int len;
        r = '0;
        if (run_len[idx] == 0)
        begin
            r.status = ST_NOTALLOC;
            return r;
        end
        len = run_len[idx];
        for (int k = 0; k < len && idx + k < NUM_CHUNKS; k++)
            chunk_free[idx + k] = 1;
        run_len[idx] = '0;
        r.status = ST_OK;
        r.chunk_index = idx;
        r.chunk_count = len[5:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHUNKS; i++)
            begin
                chunk_free[i] = 1;
                run_len[i] = '0;
            end
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            // result first: with one request in flight the order does not matter
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("unexpected result beat", 1, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.status !== want.status)
                        report_mismatch("status", out_data.status, want.status);
                    if (out_data.chunk_index !== want.chunk_index)
                        report_mismatch("chunk_index", out_data.chunk_index,
                                        want.chunk_index);
                    if (out_data.chunk_count !== want.chunk_count)
                        report_mismatch("chunk_count", out_data.chunk_count,
                                        want.chunk_count);
                end
            end
            if (in_valid && !in_stall)
            begin
                if (in_data.action)
                    expected_q.push_back(release_chunks(in_data.release_index));
                else
                    expected_q.push_back(allocate_chunks(in_data.request_bytes));
            end
        end
    end
endmodule

FILE: verif/bitmap_first_fit_allocator_tb.sv
// top of the bitmap allocator testbench: clock, reset, request stimulus and verdict
module bitmap_first_fit_allocator_tb;
    import bffa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      in_valid = 0;
    logic      in_stall;
    in_beat_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 0;
    out_beat_t out_data;
    int        fail_count;
    int        pending;

    // idle percentages for sender and receiver, changed per phase
    int        send_idle = 0;
    int        recv_idle = 0;
    bit        hold_off = 0;

    // granted start chunks still live, used to aim most frees at real runs
    logic [9:0] live_starts [$];

    always #4 clk = ~clk;

    bitmap_first_fit_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    bitmap_first_fit_allocator_chk chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: random stall, or a constant stall while hold_off is set
    always @(posedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle);
    end

    // remember granted starts from the result beats
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall && out_data.status == ST_OK)
        begin
            if (live_starts.size() < 256)
                live_starts.push_back(out_data.chunk_index);
        end
    end

    // one request beat; random idle cycles before it, then wait for acceptance
    task automatic send_beat(input logic act, input logic [11:0] bytes,
                             input logic [9:0] idx);
        while ($urandom_range(99) < send_idle)
            @(posedge clk);
        in_valid <= 1'b1;
        in_data  <= '{action: act, request_bytes: bytes, release_index: idx};
        do
            @(posedge clk);
        while (in_stall);
        in_valid <= 1'b0;
        // the block stalls further input while it handles this beat anyway
        @(posedge clk);
    endtask

    task automatic send_alloc(input logic [11:0] bytes);
        send_beat(1'b0, bytes, 10'($urandom));
    endtask

    task automatic send_free(input logic [9:0] idx);
        send_beat(1'b1, 12'($urandom), idx);
    endtask

    // mostly well-formed traffic: small allocates, frees of live runs
    task automatic random_traffic(input int n);
        int pick;
        int sel;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 50)
                send_alloc(12'($urandom_range(1, 216)));
            else if (pick < 55)
                send_alloc(12'($urandom));
            else if (pick < 90 && live_starts.size() > 0)
            begin
                sel = $urandom_range(live_starts.size() - 1);
                send_free(live_starts[sel]);
                live_starts.delete(sel);
            end
            else
                send_free(10'($urandom));
        end
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: size edges, free edges, fill to no space, end of map
        send_alloc(12'd0);
        send_alloc(12'd1);
        send_alloc(12'd4);
        send_alloc(12'd5);
        send_alloc(12'd216);
        send_alloc(12'd217);
        send_alloc(12'd219);
        send_alloc(12'd220);
        send_alloc(12'hFFF);
        send_free(10'd0);
        send_free(10'd0);
        send_free(10'd1023);
        send_free(10'd3);
        drain();
        // fill the map with 56-chunk runs, the last tail is too short: no space
        for (int i = 0; i < 19; i++)
            send_alloc(12'd216);
        send_alloc(12'd1);
        drain();
        // free index 952, which starts no run: not allocated
        send_free(10'd952);
        drain();
        live_starts.delete();

        // no idling
        random_traffic(300);
        drain();
        send_idle = 77;
        random_traffic(250);
        send_idle = 0;
        recv_idle = 77;
        random_traffic(250);
        send_idle = 16;
        recv_idle = 16;
        random_traffic(250);

        // long receiver hold-off while requests keep coming
        send_idle = 0;
        recv_idle = 0;
        fork
            begin
                hold_off = 1;
                repeat (400) @(posedge clk);
                hold_off = 0;
            end
            random_traffic(20);
        join
        // sender waits until every result is back
        drain();
        random_traffic(180);
        drain();

        if (fail_count == 0)
            $display("** bitmap_first_fit_allocator: PASSED **");
        else
            $display("** bitmap_first_fit_allocator: FAILED **");
        $finish;
    end

    initial
    begin
        #200ms;
        $display("** bitmap_first_fit_allocator: FAILED **");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/bffa_pkg.sv
rtl/core/bffa_datapath.sv
rtl/core/bffa_ctrl.sv
rtl/core/bitmap_first_fit_allocator.sv
rtl/core/bffa_checker.sv
verif/bitmap_first_fit_allocator_chk.sv
verif/bitmap_first_fit_allocator_tb.sv
